### hw/rtl/cs8_pkg.sv
// ---------------------------------------------------------------------------
// cs8_pkg
// Shared types and constants for the cycle-stepped 8-bit processor core.
// ---------------------------------------------------------------------------
package cs8_pkg;

  localparam logic [15:0] VectorAddr = 16'hFFFC;
  localparam logic [7:0]  NegBit     = 8'h80;
  localparam logic [7:0]  FlagV      = 8'h40;
  localparam logic [7:0]  FlagD      = 8'h08;
  localparam logic [7:0]  FlagI      = 8'h04;
  localparam logic [7:0]  FlagZ      = 8'h02;
  localparam logic [7:0]  FlagC      = 8'h01;
  localparam logic [15:0] StartAddrRst = 16'h0000;

  // flag and no-operation opcodes
  localparam logic [7:0] OpClc = 8'h18;
  localparam logic [7:0] OpCld = 8'hD8;
  localparam logic [7:0] OpCli = 8'h58;
  localparam logic [7:0] OpClv = 8'hB8;
  localparam logic [7:0] OpSec = 8'h38;
  localparam logic [7:0] OpSed = 8'hF8;
  localparam logic [7:0] OpSei = 8'h78;
  localparam logic [7:0] OpNop = 8'hEA;

  typedef enum logic [3:0] {
    MImpl, MImm, MZp, MZpi, MAbs, MAbi, MIndx, MIndy, MJmpa, MJmpi
  } mode_e;

  typedef enum logic [1:0] { RegA, RegX, RegY } reg_sel_e;

  typedef struct packed {
    mode_e    mode;
    reg_sel_e rsel;
    reg_sel_e isel;
    logic     store;
    logic     known;
  } decoded_t;

  function automatic decoded_t decode(input logic [7:0] op);
    decoded_t d;
    d = '{mode: MImpl, rsel: RegA, isel: RegX, store: 1'b0, known: 1'b1};
    case (op)
      8'hA9: d.mode = MImm;
      8'hA5: d.mode = MZp;
      8'hB5: d.mode = MZpi;
      8'hAD: d.mode = MAbs;
      8'hBD: d.mode = MAbi;
      8'hB9: begin d.mode = MAbi; d.isel = RegY; end
      8'hA1: d.mode = MIndx;
      8'hB1: d.mode = MIndy;
      8'hA2: begin d.mode = MImm; d.rsel = RegX; end
      8'hA6: begin d.mode = MZp; d.rsel = RegX; end
      8'hB6: begin d.mode = MZpi; d.rsel = RegX; d.isel = RegY; end
      8'hAE: begin d.mode = MAbs; d.rsel = RegX; end
      8'hBE: begin d.mode = MAbi; d.rsel = RegX; d.isel = RegY; end
      8'hA0: begin d.mode = MImm; d.rsel = RegY; end
      8'hA4: begin d.mode = MZp; d.rsel = RegY; end
      8'hB4: begin d.mode = MZpi; d.rsel = RegY; end
      8'hAC: begin d.mode = MAbs; d.rsel = RegY; end
      8'hBC: begin d.mode = MAbi; d.rsel = RegY; end
      8'h85: begin d.mode = MZp; d.store = 1'b1; end
      8'h95: begin d.mode = MZpi; d.store = 1'b1; end
      8'h8D: begin d.mode = MAbs; d.store = 1'b1; end
      8'h9D: begin d.mode = MAbi; d.store = 1'b1; end
      8'h99: begin d.mode = MAbi; d.isel = RegY; d.store = 1'b1; end
      8'h86: begin d.mode = MZp; d.rsel = RegX; d.store = 1'b1; end
      8'h96: begin d.mode = MZpi; d.rsel = RegX; d.isel = RegY; d.store = 1'b1; end
      8'h8E: begin d.mode = MAbs; d.rsel = RegX; d.store = 1'b1; end
      8'h84: begin d.mode = MZp; d.rsel = RegY; d.store = 1'b1; end
      8'h94: begin d.mode = MZpi; d.rsel = RegY; d.store = 1'b1; end
      8'h8C: begin d.mode = MAbs; d.rsel = RegY; d.store = 1'b1; end
      8'h4C: d.mode = MJmpa;
      8'h6C: d.mode = MJmpi;
      OpNop, OpClc, OpCld, OpCli, OpClv, OpSec, OpSed, OpSei: d.mode = MImpl;
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/cycle_stepped_8bit_cpu_subset_unit.sv
// ---------------------------------------------------------------------------
// cycle_stepped_8bit_cpu_subset_unit
// Cycle-stepped 8-bit processor core, one bus cycle per input beat.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one beat per bus
//   cycle: the byte read at the address given by the previous result beat.
//   The output channel (out_valid_o / out_stall_i) returns one beat per input
//   beat: next bus address, write enable and data, opcode-fetch marker, and
//   the A, X, Y, status and program counter registers, plus bad_opcode.
//   Each beat is processed by the combinational decode/execute logic between
//   the architectural registers and the output register, which captures the
//   result on accept, one beat per clock while out_stall_i is low.
//   When the receiver stalls, the output register holds its beat and the
//   input stall is raised only while a full output register is blocked.
//   After reset the first fetch beat is ignored, two idle beats follow, the
//   vector is read at 0xFFFC/0xFFFD, and the next beat loads the program
//   counter. cfg_we_i writes start_address; before the first beat it also
//   sets the program counter and the bus address.
// ---------------------------------------------------------------------------
module cycle_stepped_8bit_cpu_subset_unit import cs8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] address_o,
  output logic        write_enable_o,
  output logic [7:0]  write_data_o,
  output logic        fetch_cycle_o,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  index_x_out_o,
  output logic [7:0]  index_y_out_o,
  output logic [7:0]  flags_out_o,
  output logic [15:0] program_counter_o,
  output logic        bad_opcode_o
);

  logic [15:0] start_q;
  logic [15:0] pc_q, pc_d, opl_q, opl_d, addr_q, addr_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, p_q, p_d, op_q, op_d, ob_q, ob_d;
  logic [2:0]  cyc_q, cyc_d;
  logic        fetch_q, fetch_d, rstp_q, rstp_d, wr_d, bad_d;
  logic        accept;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // one bus cycle of the core
  always_comb begin
    decoded_t    d;
    logic [7:0]  rv, iv, ldv;
    logic [15:0] hi, sum;
    logic        ld, fin;
    pc_d = pc_q; opl_d = opl_q; addr_d = addr_q;
    a_d = a_q; x_d = x_q; y_d = y_q; p_d = p_q; op_d = op_q; ob_d = ob_q;
    cyc_d = cyc_q; fetch_d = fetch_q; rstp_d = rstp_q;
    wr_d = 1'b0; bad_d = 1'b0; ld = 1'b0; fin = 1'b0; ldv = data_in_i;
    d  = decode(op_q);
    case (d.rsel)
      RegX:    rv = x_q;
      RegY:    rv = y_q;
      default: rv = a_q;
    endcase
    case (d.isel)
      RegY:    iv = y_q;
      RegA:    iv = a_q;
      default: iv = x_q;
    endcase
    hi  = {data_in_i, 8'h00};
    sum = 16'(opl_q | hi) + {8'h00, iv};
    if (fetch_q) begin
      fetch_d = 1'b0;
      cyc_d   = 3'd0;
      if (rstp_q) begin
        op_d = 8'h00;
      end else begin
        op_d   = data_in_i;
        bad_d  = ~decode(data_in_i).known;
        pc_d   = pc_q + 16'd1;
        addr_d = pc_q + 16'd1;
      end
    end else begin
      cyc_d = cyc_q + 3'd1;
      if (rstp_q) begin
        case (cyc_q)
          3'd0, 3'd1: ;
          3'd2: addr_d = VectorAddr;
          3'd3: begin opl_d = {8'h00, data_in_i}; addr_d = addr_q + 16'd1; end
          3'd4: begin opl_d = opl_q | hi; addr_d = opl_q | hi; end
          default: begin pc_d = opl_q; rstp_d = 1'b0; fin = 1'b1; end
        endcase
      end else begin
        case (d.mode)
          MImm: begin pc_d = pc_q + 16'd1; ld = 1'b1; end
          MZp: begin
            if (cyc_q == 3'd0) begin
              pc_d = pc_q + 16'd1; addr_d = {8'h00, data_in_i};
              if (d.store) begin wr_d = 1'b1; ob_d = rv; end
            end else if (d.store) fin = 1'b1;
            else ld = 1'b1;
          end
          MZpi: begin
            if (cyc_q == 3'd0) begin
              opl_d = {8'h00, data_in_i}; addr_d = {8'h00, data_in_i};
              pc_d = pc_q + 16'd1;
            end else if (cyc_q == 3'd1) begin
              addr_d = {8'h00, opl_q[7:0] + iv};
              if (d.store) begin wr_d = 1'b1; ob_d = rv; end
            end else if (d.store) fin = 1'b1;
            else ld = 1'b1;
          end
          MAbs: begin
            if (cyc_q == 3'd0) begin
              opl_d = {8'h00, data_in_i}; pc_d = pc_q + 16'd1; addr_d = pc_q + 16'd1;
            end else if (cyc_q == 3'd1) begin
              opl_d = opl_q | hi; pc_d = pc_q + 16'd1; addr_d = opl_q | hi;
              if (d.store) begin wr_d = 1'b1; ob_d = rv; end
            end else if (d.store) fin = 1'b1;
            else ld = 1'b1;
          end
          MAbi: begin
            if (cyc_q == 3'd0) begin
              opl_d = {8'h00, data_in_i}; pc_d = pc_q + 16'd1; addr_d = pc_q + 16'd1;
            end else if (cyc_q == 3'd1) begin
              pc_d = pc_q + 16'd1;
              if (d.store) opl_d = sum;
              else begin opl_d = opl_q | hi; addr_d = sum; end
            end else if (cyc_q == 3'd2) begin
              if (d.store) begin addr_d = opl_q; wr_d = 1'b1; ob_d = rv; end
              else if (addr_q[15:8] == opl_q[15:8]) ld = 1'b1;
            end else if (d.store) fin = 1'b1;
            else ld = 1'b1;
          end
          MIndx: begin
            case (cyc_q)
              3'd0: begin
                opl_d = {8'h00, data_in_i}; addr_d = {8'h00, data_in_i};
                pc_d = pc_q + 16'd1;
              end
              3'd1: addr_d = {8'h00, opl_q[7:0] + x_q};
              3'd2: begin
                opl_d = {8'h00, data_in_i}; addr_d = {8'h00, addr_q[7:0] + 8'd1};
              end
              3'd3: begin opl_d = opl_q | hi; addr_d = opl_q | hi; end
              default: ld = 1'b1;
            endcase
          end
          MIndy: begin
            case (cyc_q)
              3'd0: begin addr_d = {8'h00, data_in_i}; pc_d = pc_q + 16'd1; end
              3'd1: begin
                opl_d = {8'h00, data_in_i}; addr_d = {8'h00, addr_q[7:0] + 8'd1};
              end
              3'd2: begin
                opl_d = opl_q | hi; addr_d = (opl_q | hi) + {8'h00, y_q};
              end
              3'd3: if (addr_q[15:8] == opl_q[15:8]) ld = 1'b1;
              default: ld = 1'b1;
            endcase
          end
          MJmpa: begin
            if (cyc_q == 3'd0) begin
              opl_d = {8'h00, data_in_i}; pc_d = pc_q + 16'd1; addr_d = pc_q + 16'd1;
            end else begin pc_d = opl_q | hi; fin = 1'b1; end
          end
          MJmpi: begin
            case (cyc_q)
              3'd0: begin
                opl_d = {8'h00, data_in_i}; pc_d = pc_q + 16'd1; addr_d = pc_q + 16'd1;
              end
              3'd1: begin opl_d = opl_q | hi; pc_d = pc_q + 16'd1; addr_d = opl_q | hi; end
              3'd2: begin opl_d = {8'h00, data_in_i}; addr_d = addr_q + 16'd1; end
              default: begin pc_d = opl_q | hi; fin = 1'b1; end
            endcase
          end
          default: begin
            case (op_q)
              OpClc: p_d = p_q & ~FlagC;
              OpCld: p_d = p_q & ~FlagD;
              OpCli: p_d = p_q & ~FlagI;
              OpClv: p_d = p_q & ~FlagV;
              OpSec: p_d = p_q | FlagC;
              OpSed: p_d = p_q | FlagD;
              OpSei: p_d = p_q | FlagI;
              default: ;
            endcase
            fin = 1'b1;
          end
        endcase
      end
      // load writeback with N/Z update
      if (ld) begin
        case ((d.mode == MIndx || d.mode == MIndy) ? RegA : d.rsel)
          RegX:    x_d = ldv;
          RegY:    y_d = ldv;
          default: a_d = ldv;
        endcase
        p_d = (p_q & ~(FlagZ | NegBit)) | ((ldv == 8'h00) ? FlagZ : 8'h00)
              | (ldv & NegBit);
        fin = 1'b1;
      end
      if (fin) begin fetch_d = 1'b1; addr_d = pc_d; end
    end
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartAddrRst; pc_q <= StartAddrRst; addr_q <= StartAddrRst;
      opl_q <= '0; a_q <= '0; x_q <= '0; y_q <= '0; p_q <= '0; op_q <= '0;
      ob_q <= '0; cyc_q <= '0; fetch_q <= 1'b1; rstp_q <= 1'b1;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
      if (rstp_q && fetch_q) begin pc_q <= cfg_wdata_i; addr_q <= cfg_wdata_i; end
    end else if (accept) begin
      pc_q <= pc_d; addr_q <= addr_d; opl_q <= opl_d; a_q <= a_d; x_q <= x_d;
      y_q <= y_d; p_q <= p_d; op_q <= op_d; ob_q <= ob_d; cyc_q <= cyc_d;
      fetch_q <= fetch_d; rstp_q <= rstp_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (accept) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      address_o         <= addr_d;
      write_enable_o    <= wr_d;
      write_data_o      <= wr_d ? ob_d : 8'h00;
      fetch_cycle_o     <= fetch_d;
      accumulator_o     <= a_d;
      index_x_out_o     <= x_d;
      index_y_out_o     <= y_d;
      flags_out_o       <= p_d;
      program_counter_o <= pc_d;
      bad_opcode_o      <= bad_d;
    end
  end

endmodule
